// ===== rtl/core/conv2d_multichannel_forward_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel convolution block.
// Each macro expands to one labeled concurrent assertion on clk_i.
// ----------------------------------------------------------------------------
`ifndef CONV2D_MULTICHANNEL_FORWARD_ASSERT_SVH
`define CONV2D_MULTICHANNEL_FORWARD_ASSERT_SVH

// Checked only while reset is released.
`define C2D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define C2D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/c2d_pkg.sv =====
// ----------------------------------------------------------------------------
// c2d_pkg
// Types, codes and default sizes shared by the convolution block and its
// checker.
// ----------------------------------------------------------------------------
package c2d_pkg;

  localparam int C2D_MAX_IN_CH    = 4;
  localparam int C2D_MAX_OUT_CH   = 8;
  localparam int C2D_MAX_KERNEL   = 5;
  localparam int C2D_MAX_OUT_DIM  = 32;
  localparam int C2D_WEIGHT_DEPTH = 1024;
  localparam int C2D_INPUT_DEPTH  = 8192;

  // Byte address width of the register port: six registers at 4*i.
  localparam int C2D_PADDR_W = 5;

  typedef enum logic [1:0] {
    OP_WR_WEIGHT = 2'd0,
    OP_WR_SAMPLE = 2'd1,
    OP_COMPUTE   = 2'd2
  } c2d_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_RANGE = 2'd2
  } c2d_status_e;

  typedef enum logic [2:0] {
    REG_IN_CH  = 3'd0,
    REG_OUT_CH = 3'd1,
    REG_ROWS   = 3'd2,
    REG_COLS   = 3'd3,
    REG_KROWS  = 3'd4,
    REG_KCOLS  = 3'd5
  } c2d_reg_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [12:0]        address;
    logic signed [15:0] value;
    logic [2:0]         out_channel;
    logic [4:0]         out_row;
    logic [4:0]         out_col;
  } c2d_req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         status;
  } c2d_rsp_t;

endpackage

// ===== rtl/core/conv2d_multichannel_forward.sv =====
// ----------------------------------------------------------------------------
// conv2d_multichannel_forward
// Forward pass of a valid-only multichannel 2D convolution with one bias per
// output channel, built around a weight memory and a sample memory.
// ----------------------------------------------------------------------------
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+---------------------------------
//   request   | start in, busy out        | req_i  (opcode, address, value,
//             |                           |         out_channel/row/col)
//   response  | done_o strobe, one cycle  | rsp_o  (result, status)
//   config    | APB psel/penable/pwrite   | paddr, pwdata, prdata
//
// A weight or sample load is written into its memory at the edge that
// accepts the transaction; busy never rises for it. A compute transaction
// keeps busy high through the setup states S_PREP1, S_PREP2, S_PREP3 and
// S_DECIDE, then one multiply-accumulate per cycle (one weight and one
// sample read per cycle, the memory read ports set the pace), the bias read
// in S_BIAS, and S_DRAIN until the pipeline has emptied into the accumulator.
// A compute that fails a range check ends in S_DECIDE, at the end of setup.
// The result is shown on rsp_o for one cycle with done_o, in the first
// cycle in which busy is low again, so the next transaction can be accepted
// while the result is on the port. The receiver cannot stall.
// Reset clears the control state and sets every configuration register to
// one; the memories are not cleared and need no clearing pass.
//
module conv2d_multichannel_forward #(
  parameter int MAX_IN_CH    = c2d_pkg::C2D_MAX_IN_CH,
  parameter int MAX_OUT_CH   = c2d_pkg::C2D_MAX_OUT_CH,
  parameter int MAX_KERNEL   = c2d_pkg::C2D_MAX_KERNEL,
  parameter int MAX_OUT_DIM  = c2d_pkg::C2D_MAX_OUT_DIM,
  parameter int WEIGHT_DEPTH = c2d_pkg::C2D_WEIGHT_DEPTH,
  parameter int INPUT_DEPTH  = c2d_pkg::C2D_INPUT_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request channel
  input  logic                              start,
  output logic                              busy,
  input  c2d_pkg::c2d_req_t                 req_i,
  // Response channel
  output logic                              done_o,
  output c2d_pkg::c2d_rsp_t                 rsp_o,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [c2d_pkg::C2D_PADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // Memory index widths and the widths of the walking pointers. The pointers
  // are at least as wide as the largest layout the registers can describe.
  localparam int WAW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int IAW = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int WPW = (WAW > 13) ? WAW : 13;
  localparam int SPW = (IAW > 17) ? IAW : 17;
  localparam int ACC_W = 41;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP1,
    S_PREP2,
    S_PREP3,
    S_DECIDE,
    S_RUN,
    S_BIAS,
    S_DRAIN
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [2:0] cfg_in_ch_q;
  logic [3:0] cfg_out_ch_q;
  logic [5:0] cfg_rows_q;
  logic [5:0] cfg_cols_q;
  logic [2:0] cfg_krows_q;
  logic [2:0] cfg_kcols_q;

  // Coordinates of the output being computed.
  logic [2:0] oc_q;
  logic [4:0] row_q;
  logic [4:0] col_q;

  // Layout figures, built up over the setup states S_PREP1 to S_PREP3.
  logic        ok_q;
  logic [5:0]  kk_q;
  logic [6:0]  inr_q;
  logic [6:0]  inc_q;
  logic [8:0]  taps_q;
  logic [9:0]  insza_q;
  logic [11:0] xinc_q;
  logic [12:0] chrow_q;
  logic [12:0] wlim_q;
  logic [12:0] wbase_q;
  logic [16:0] insz_q;
  logic [12:0] sbase_q;
  logic [12:0] chstep_q;
  logic [9:0]  block;

  // Walk over the kernel window.
  logic [WPW-1:0] wp_q;
  logic [SPW-1:0] sp_q;
  logic [2:0]     ci_q;
  logic [2:0]     dx_q;
  logic [2:0]     dy_q;
  logic           last_dy;
  logic           last_dx;
  logic           last_tap;

  // Multiply-accumulate pipeline.
  logic                    rd_issue;
  logic                    rd_vld_q;
  logic                    rd_bias_q;
  logic                    mul_vld_q;
  logic signed [15:0]      w_rd_q;
  logic signed [15:0]      s_rd_q;
  logic signed [15:0]      mul_b;
  logic signed [31:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    acc_fits;

  // Load path.
  logic           accept;
  logic [WPW-1:0] wr_waddr;
  logic [SPW-1:0] wr_saddr;
  logic           w_we;
  logic           s_we;
  logic           cfg_we;

  logic           done_q;
  c2d_pkg::c2d_rsp_t rsp_q;

  // The two memories; their contents are defined only where written.
  logic signed [15:0] w_mem [WEIGHT_DEPTH];
  logic signed [15:0] s_mem [INPUT_DEPTH];

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // A load whose address lies beyond its memory is dropped.
  assign wr_waddr = WPW'(req_i.address);
  assign wr_saddr = SPW'(req_i.address);
  assign w_we = accept && (req_i.opcode == c2d_pkg::OP_WR_WEIGHT)
                && (32'(req_i.address) < WEIGHT_DEPTH);
  assign s_we = accept && (req_i.opcode == c2d_pkg::OP_WR_SAMPLE)
                && (32'(req_i.address) < INPUT_DEPTH);

  // One read of each memory per cycle while the window is walked. The bias
  // read uses the weight port only; the sample read in that cycle is unused.
  assign rd_issue = (state_q == S_RUN) || (state_q == S_BIAS);

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[wr_waddr[WAW-1:0]] <= req_i.value;
    end
    if (rd_issue) begin
      w_rd_q <= w_mem[wp_q[WAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[wr_saddr[IAW-1:0]] <= req_i.value;
    end
    if (rd_issue) begin
      s_rd_q <= s_mem[sp_q[IAW-1:0]];
    end
  end

  // Kernel window position. Weights are laid out in the same order as the
  // walk, so the weight pointer just counts up and ends on the bias entry.
  assign last_dy  = (dy_q == cfg_kcols_q - 3'd1);
  assign last_dx  = (dx_q == cfg_krows_q - 3'd1);
  assign last_tap = last_dy && last_dx && (ci_q == cfg_in_ch_q - 3'd1);

  assign block = 10'(taps_q) + 10'd1;

  // The bias is a Q8.8 weight moved into Q16.16, so it is multiplied by 256.
  assign mul_b = rd_bias_q ? 16'sd256 : s_rd_q;

  // The sum fits in 32 bits when its upper bits are all copies of bit 31.
  assign acc_fits = (acc_q[ACC_W-1:31] == '0) || (acc_q[ACC_W-1:31] == '1);

  always_comb begin
    unique case (c2d_pkg::c2d_reg_e'(paddr[4:2]))
      c2d_pkg::REG_IN_CH:  prdata = 32'(cfg_in_ch_q);
      c2d_pkg::REG_OUT_CH: prdata = 32'(cfg_out_ch_q);
      c2d_pkg::REG_ROWS:   prdata = 32'(cfg_rows_q);
      c2d_pkg::REG_COLS:   prdata = 32'(cfg_cols_q);
      c2d_pkg::REG_KROWS:  prdata = 32'(cfg_krows_q);
      c2d_pkg::REG_KCOLS:  prdata = 32'(cfg_kcols_q);
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_in_ch_q  <= 3'd1;
      cfg_out_ch_q <= 4'd1;
      cfg_rows_q   <= 6'd1;
      cfg_cols_q   <= 6'd1;
      cfg_krows_q  <= 3'd1;
      cfg_kcols_q  <= 3'd1;
    end else if (cfg_we) begin
      unique case (c2d_pkg::c2d_reg_e'(paddr[4:2]))
        c2d_pkg::REG_IN_CH:  cfg_in_ch_q  <= pwdata[2:0];
        c2d_pkg::REG_OUT_CH: cfg_out_ch_q <= pwdata[3:0];
        c2d_pkg::REG_ROWS:   cfg_rows_q   <= pwdata[5:0];
        c2d_pkg::REG_COLS:   cfg_cols_q   <= pwdata[5:0];
        c2d_pkg::REG_KROWS:  cfg_krows_q  <= pwdata[2:0];
        c2d_pkg::REG_KCOLS:  cfg_kcols_q  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Sequencer, address walk, multiply-accumulate and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      rsp_q     <= '0;
      oc_q      <= '0;
      row_q     <= '0;
      col_q     <= '0;
      ok_q      <= 1'b0;
      kk_q      <= '0;
      inr_q     <= '0;
      inc_q     <= '0;
      taps_q    <= '0;
      insza_q   <= '0;
      xinc_q    <= '0;
      chrow_q   <= '0;
      wlim_q    <= '0;
      wbase_q   <= '0;
      insz_q    <= '0;
      sbase_q   <= '0;
      chstep_q  <= '0;
      wp_q      <= '0;
      sp_q      <= '0;
      ci_q      <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
      rd_vld_q  <= 1'b0;
      rd_bias_q <= 1'b0;
      mul_vld_q <= 1'b0;
      prod_q    <= '0;
      acc_q     <= '0;
    end else begin
      done_q    <= 1'b0;
      rd_vld_q  <= rd_issue;
      rd_bias_q <= (state_q == S_BIAS);
      mul_vld_q <= rd_vld_q;
      if (rd_vld_q) begin
        prod_q <= w_rd_q * mul_b;
      end
      if (mul_vld_q) begin
        acc_q <= acc_q + {{(ACC_W-32){prod_q[31]}}, prod_q};
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept && (req_i.opcode == c2d_pkg::OP_COMPUTE)) begin
            oc_q    <= req_i.out_channel;
            row_q   <= req_i.out_row;
            col_q   <= req_i.out_col;
            state_q <= S_PREP1;
          end
        end
        S_PREP1: begin
          ok_q <= (cfg_in_ch_q != 3'd0) && (32'(cfg_in_ch_q) <= MAX_IN_CH)
               && (cfg_out_ch_q != 4'd0) && (32'(cfg_out_ch_q) <= MAX_OUT_CH)
               && (cfg_rows_q != 6'd0) && (32'(cfg_rows_q) <= MAX_OUT_DIM)
               && (cfg_cols_q != 6'd0) && (32'(cfg_cols_q) <= MAX_OUT_DIM)
               && (cfg_krows_q != 3'd0) && (32'(cfg_krows_q) <= MAX_KERNEL)
               && (cfg_kcols_q != 3'd0) && (32'(cfg_kcols_q) <= MAX_KERNEL)
               && ({1'b0, oc_q} < cfg_out_ch_q)
               && ({1'b0, row_q} < cfg_rows_q)
               && ({1'b0, col_q} < cfg_cols_q);
          kk_q    <= 6'(cfg_krows_q) * 6'(cfg_kcols_q);
          inr_q   <= 7'(cfg_rows_q) + 7'(cfg_krows_q) - 7'd1;
          inc_q   <= 7'(cfg_cols_q) + 7'(cfg_kcols_q) - 7'd1;
          state_q <= S_PREP2;
        end
        S_PREP2: begin
          taps_q  <= 9'(cfg_in_ch_q) * 9'(kk_q);
          insza_q <= 10'(cfg_in_ch_q) * 10'(inr_q);
          xinc_q  <= 12'(row_q) * 12'(inc_q);
          chrow_q <= 13'(cfg_rows_q) * 13'(inc_q);
          state_q <= S_PREP3;
        end
        S_PREP3: begin
          wlim_q   <= (13'(oc_q) + 13'd1) * 13'(block);
          wbase_q  <= 13'(oc_q) * 13'(block);
          insz_q   <= 17'(insza_q) * 17'(inc_q);
          sbase_q  <= 13'(xinc_q) + 13'(col_q);
          // Step from the last tap of one channel to the first of the next.
          chstep_q <= chrow_q - 13'(cfg_kcols_q) + 13'd1;
          state_q  <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!ok_q || (32'(wlim_q) > WEIGHT_DEPTH) || (32'(insz_q) > INPUT_DEPTH)) begin
            rsp_q.result <= '0;
            rsp_q.status <= c2d_pkg::ST_RANGE;
            done_q       <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            wp_q    <= WPW'(wbase_q);
            sp_q    <= SPW'(sbase_q);
            ci_q    <= '0;
            dx_q    <= '0;
            dy_q    <= '0;
            acc_q   <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          wp_q <= wp_q + WPW'(1);
          if (last_tap) begin
            state_q <= S_BIAS;
          end else if (!last_dy) begin
            dy_q <= dy_q + 3'd1;
            sp_q <= sp_q + SPW'(1);
          end else if (!last_dx) begin
            // Next kernel row: skip the samples outside the window.
            dy_q <= '0;
            dx_q <= dx_q + 3'd1;
            sp_q <= sp_q + SPW'(cfg_cols_q);
          end else begin
            dy_q <= '0;
            dx_q <= '0;
            ci_q <= ci_q + 3'd1;
            sp_q <= sp_q + SPW'(chstep_q);
          end
        end
        S_BIAS: begin
          state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!rd_vld_q && !mul_vld_q) begin
            if (acc_fits) begin
              rsp_q.result <= acc_q[31:0];
              rsp_q.status <= c2d_pkg::ST_OK;
            end else begin
              rsp_q.result <= acc_q[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
              rsp_q.status <= c2d_pkg::ST_SAT;
            end
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/c2d_checker.sv =====
// ----------------------------------------------------------------------------
// c2d_checker
// Port-level checks of the convolution block, bound to its top level.
// ----------------------------------------------------------------------------
`include "conv2d_multichannel_forward_assert.svh"

module c2d_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input c2d_pkg::c2d_req_t req_i,
  input logic              done_o,
  input c2d_pkg::c2d_rsp_t rsp_o
);

  // A compute transaction always occupies the block.
  `C2D_ASSERT(a_compute_busy, start && !busy && (req_i.opcode == c2d_pkg::OP_COMPUTE) |=> busy, "compute did not raise busy")

  // Loads complete in the accepting cycle.
  `C2D_ASSERT(a_load_no_busy, start && !busy && (req_i.opcode != c2d_pkg::OP_COMPUTE) |=> !busy, "load raised busy")

  // Every compute ends with exactly one result, shown as busy falls.
  `C2D_ASSERT(a_done_on_fall, done_o == $fell(busy), "result strobe out of step with busy")

  // A cycle spent in reset leaves the block idle with no result.
  `C2D_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !busy && !done_o, "block active after reset")

endmodule

bind conv2d_multichannel_forward c2d_checker u_c2d_checker (.*);
